[design/sacf_pkg.sv]
`timescale 1ns / 1ps
package sacf_pkg;
	localparam int WAYS_DEF        = 3;
	localparam int TRACKED_DEF     = 8;
	localparam int MAX_GB_DEF      = 10;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int KEY_BITS_DEF    = 64;
	localparam int TAG_BITS        = 16;
	localparam int HASH_BITS       = 32;
	localparam int KLEN_BITS       = 4;
	localparam int VLEN_BITS       = 16;
	localparam int GB_BITS         = 4;
	localparam int GROUP_OUT_BITS  = 10;
	localparam int WAY_OUT_BITS    = 2;
	localparam logic CMD_LOOKUP    = 1'b0;
	localparam logic CMD_INSERT    = 1'b1;

	// request after classification in the front end
	typedef struct packed {
		logic        ins;
		logic [HASH_BITS-1:0] hash;
		logic [KEY_BITS_DEF-1:0] key;
		logic [KLEN_BITS-1:0] klen;
		logic [VLEN_BITS-1:0] vlen;
	} req_t;
endpackage

[design/set_assoc_cache_frequency_policy_unit.sv]
`timescale 1ns / 1ps
// channel | handshake          | payload
// in      | in_valid/in_stall  | cmd, key_hash, key, key_length, value_length
// out     | out_valid/out_stall| found, is_new, group, way
// cfg     | cfg_valid/cfg_ready| cfg_data (group_bits)
// A transaction in the back end is a group row read, then update and write back.
// The next row read may share the edge at which the previous result is taken.
// After reset a clearing pass zeroes all 2**MAX_GROUP_BITS rows (1024 by default);
// no input is consumed meanwhile (the front queue still fills, two deep).
// Output stall holds the result register; the back end waits, the queue absorbs.
module set_assoc_cache_frequency_policy_unit import sacf_pkg::*; #(
	parameter int WAYS = WAYS_DEF,
	parameter int TRACKED = TRACKED_DEF,
	parameter int MAX_GROUP_BITS = MAX_GB_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [HASH_BITS-1:0] key_hash,
	input  logic [KEY_BITS_DEF-1:0] key,
	input  logic [KLEN_BITS-1:0] key_length,
	input  logic [VLEN_BITS-1:0] value_length,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic is_new,
	output logic [GROUP_OUT_BITS-1:0] group,
	output logic [WAY_OUT_BITS-1:0] way,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [GB_BITS-1:0] cfg_data
);
	logic q_valid, q_pop, busy;
	req_t q_data;
	logic [GB_BITS-1:0] gb_q;

	// config taken only with nothing queued, executing or waiting at the output
	assign cfg_ready = !busy && !q_valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gb_q <= '0;
		else if (cfg_valid && cfg_ready) gb_q <= cfg_data;
	end

	sacf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .key_hash, .key, .key_length,
		.value_length, .q_valid, .q_data, .q_pop
	);

	sacf_back #(.WAYS(WAYS), .TRACKED(TRACKED), .MAX_GROUP_BITS(MAX_GROUP_BITS),
		.COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .group_bits(gb_q), .q_valid, .q_data, .q_pop, .out_valid,
		.out_stall, .found, .is_new, .group, .way, .busy
	);
endmodule

[design/sacf_front.sv]
`timescale 1ns / 1ps
module sacf_front import sacf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [HASH_BITS-1:0] key_hash,
	input  logic [KEY_BITS_DEF-1:0] key,
	input  logic [KLEN_BITS-1:0] key_length,
	input  logic [VLEN_BITS-1:0] value_length,
	output logic q_valid,
	output req_t q_data,
	input  logic q_pop
);
	localparam int KEY_BITS = KEY_BITS_DEF;
	localparam int KBYTES = KEY_BITS / 8;
	localparam int DEPTH = 2;
	req_t fifo_q [DEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic [KLEN_BITS-1:0] kl;
	logic [KEY_BITS_DEF-1:0] km;
	req_t r;
	logic push;

	always_comb begin
		kl = (key_length > KLEN_BITS'(KBYTES)) ? KLEN_BITS'(KBYTES) : key_length;
		km = '0;
		for (int b = 0; b < KBYTES; b++)
			if (KLEN_BITS'(b) < kl) km[b*8 +: 8] = key[b*8 +: 8];
		r.ins = (cmd == CMD_INSERT);
		r.hash = key_hash;
		r.key = km;
		r.klen = kl;
		r.vlen = value_length;
	end

	assign in_stall = (cnt_q == 2'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	property p_pop_valid; @(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid; endproperty
	a_pop_valid: assert property (p_pop_valid) else $error("pop from empty queue");
	property p_cnt_range; @(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH); endproperty
	a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");
	property p_push_room; @(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'(DEPTH)); endproperty
	a_push_room: assert property (p_push_room) else $error("push into full queue");
endmodule

[design/sacf_back.sv]
`timescale 1ns / 1ps
module sacf_back import sacf_pkg::*; #(
	parameter int WAYS = WAYS_DEF,
	parameter int TRACKED = TRACKED_DEF,
	parameter int MAX_GROUP_BITS = MAX_GB_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [GB_BITS-1:0] group_bits,
	input  logic q_valid,
	input  req_t q_data,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic is_new,
	output logic [GROUP_OUT_BITS-1:0] group,
	output logic [WAY_OUT_BITS-1:0] way,
	output logic busy
);
	localparam int SLOTS = (TRACKED > WAYS) ? TRACKED : WAYS;
	localparam int NG = 1 << MAX_GROUP_BITS;
	localparam int GW = (MAX_GROUP_BITS > 0) ? MAX_GROUP_BITS : 1;
	localparam int SW = $clog2(SLOTS + 1);
	localparam int TW = $clog2(SLOTS);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [COUNT_BITS-1:0] PACE = COUNT_BITS'(TRACKED);

	localparam logic [1:0] ST_CLR = 2'd0, ST_IDLE = 2'd1, ST_EXEC = 2'd2;

	typedef struct packed {
		logic [WAYS-1:0] vld;
		logic [WAYS-1:0][KEY_BITS_DEF-1:0] key;
		logic [WAYS-1:0][KLEN_BITS-1:0] kl;
		logic [WAYS-1:0][VLEN_BITS-1:0] vl;
		logic [SLOTS-1:0][TAG_BITS-1:0] tag;
		logic [SLOTS:0][COUNT_BITS-1:0] cnt;
	} row_t;

	row_t mem [NG];
	row_t rd_s1, wrow;
	logic [1:0] st_q;
	logic [GW-1:0] clr_q, g_s1, g;
	req_t req_s1;
	logic ov_q, found_q, new_q;
	logic [GROUP_OUT_BITS-1:0] grp_q;
	logic [WAY_OUT_BITS-1:0] way_q;
	logic [GB_BITS-1:0] gb;
	logic wen, res_f, res_n;
	logic [WW-1:0] res_w;
	logic [TAG_BITS-1:0] tag;

	always_comb begin
		gb = (int'(group_bits) > MAX_GROUP_BITS) ? GB_BITS'(MAX_GROUP_BITS) : group_bits;
		g = GW'(q_data.hash & ((HASH_BITS'(1) << gb) - HASH_BITS'(1)));
	end

	// a new row read may share the edge at which the previous result leaves
	assign q_pop = (st_q == ST_IDLE) && q_valid && (!ov_q || !out_stall);
	assign busy = (st_q != ST_IDLE) || ov_q;

	always_ff @(posedge clk) begin
		if (q_pop) rd_s1 <= mem[g];
		if (q_pop) begin
			req_s1 <= q_data;
			g_s1 <= g;
		end
		if (st_q == ST_CLR) mem[clr_q] <= '0;
		else if (wen) mem[g_s1] <= wrow;
	end

	// execute: compare ways, then on insert take a free way, then tracked slots, then age
	always_comb begin
		logic done, hitw;
		logic [COUNT_BITS-1:0] ci;
		logic [WW-1:0] hi;
		wrow = rd_s1;
		tag = req_s1.hash[HASH_BITS-1 -: TAG_BITS];
		done = 1'b0; res_f = 1'b0; res_n = 1'b0; res_w = '0;
		hitw = 1'b0; hi = '0; ci = '0;
		for (int i = 0; i < WAYS; i++)
			if (!hitw && rd_s1.tag[i] == tag && rd_s1.vld[i] && rd_s1.kl[i] == req_s1.klen
				&& rd_s1.key[i] == req_s1.key) begin
				hitw = 1'b1; hi = WW'(i);
			end
		if (hitw) begin
			done = 1'b1; res_f = 1'b1; res_w = hi;
			res_n = req_s1.ins && (req_s1.vlen > rd_s1.vl[hi]);
		end
		if (!done && req_s1.ins)
			for (int i = 0; i < WAYS; i++)
				if (!done && (!rd_s1.vld[i] || rd_s1.cnt[i] == '0)) begin
					done = 1'b1; res_f = 1'b1; res_n = 1'b1; res_w = WW'(i);
				end
		if (!done)
			for (int i = WAYS; i < TRACKED; i++)
				if (!done && rd_s1.tag[i] == tag) begin
					done = 1'b1;
					ci = (rd_s1.cnt[i] != CMAX) ? rd_s1.cnt[i] + 1'b1 : rd_s1.cnt[i];
					wrow.cnt[i] = ci;
					if (req_s1.ins)
						for (int j = 0; j < WAYS; j++)
							if (!res_f && ci > rd_s1.cnt[j]) begin
								res_f = 1'b1; res_n = 1'b1; res_w = WW'(j);
								wrow.cnt[i] = rd_s1.cnt[j];
								wrow.cnt[j] = ci - 1'b1;
								wrow.tag[i] = rd_s1.tag[j];
							end
				end
		if (!done) begin
			if (rd_s1.cnt[SLOTS] != '0) wrow.cnt[SLOTS] = rd_s1.cnt[SLOTS] - 1'b1;
			else begin
				for (int s = 0; s < SLOTS; s++)
					if (rd_s1.cnt[s] != '0) wrow.cnt[s] = rd_s1.cnt[s] - 1'b1;
				// pacer reload, then its own decrement
				wrow.cnt[SLOTS] = (PACE != '0) ? PACE - 1'b1 : PACE;
			end
		end
		if (res_n) begin
			wrow.tag[TW'(res_w)] = tag;
			wrow.vld[res_w] = 1'b1;
			wrow.key[res_w] = req_s1.key;
			wrow.kl[res_w] = req_s1.klen;
			wrow.vl[res_w] = req_s1.vlen;
		end
		if (res_f)
			wrow.cnt[SW'(res_w)] = (wrow.cnt[SW'(res_w)] != CMAX)
				? wrow.cnt[SW'(res_w)] + 1'b1 : wrow.cnt[SW'(res_w)];
	end

	assign wen = (st_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == GW'(NG - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (q_pop) st_q <= ST_EXEC;
				ST_EXEC: begin
					st_q <= ST_IDLE;
					ov_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			found_q <= res_f;
			new_q <= res_n;
			grp_q <= res_f ? GROUP_OUT_BITS'(g_s1) : '0;
			way_q <= res_f ? WAY_OUT_BITS'(res_w) : '0;
		end
	end

	assign out_valid = ov_q;
	assign found = found_q;
	assign is_new = new_q;
	assign group = grp_q;
	assign way = way_q;

	property p_no_pop_clr; @(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> !q_pop; endproperty
	a_no_pop_clr: assert property (p_no_pop_clr) else $error("pop during clear");
	property p_exec_one; @(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXEC) |=> (st_q == ST_IDLE) && ov_q; endproperty
	a_exec_one: assert property (p_exec_one) else $error("exec not followed by result");
	property p_new_found; @(posedge clk) disable iff (!arst_n)
		ov_q && is_new |-> found; endproperty
	a_new_found: assert property (p_new_found) else $error("new without found");
endmodule
